>>> hdl/cllt_pkg.sv
// Package for the cursor linked list table: sizes, command and status codes,
// datapath micro-operations, controller states and the control structs.
// No dependencies.
`default_nettype none
package cllt_pkg;

  localparam int ENTRIES    = 16;
  localparam int VALUE_BITS = 32;
  localparam int IW         = $clog2(ENTRIES);

  typedef enum logic [2:0] {
    CMD_INIT       = 3'd0,
    CMD_MAKE_EMPTY = 3'd1,
    CMD_PUSH       = 3'd2,
    CMD_POP        = 3'd3,
    CMD_FIND       = 3'd4,
    CMD_FIND_PREV  = 3'd5,
    CMD_DELETE     = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR_START,
    OP_CLR_STEP,
    OP_RD_FREE,
    OP_TAKE,
    OP_UNLINK,
    OP_ME_SET,
    OP_PU_FILL,
    OP_PU_LINK,
    OP_PO_START,
    OP_PO_CUT,
    OP_FR_RD0,
    OP_FR_LINK,
    OP_FR_HEAD,
    OP_SK_START,
    OP_SK_Q,
    OP_SK_STEP,
    OP_SK_HIT,
    OP_DL_CUT,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [4:0] {
    S_RCLR,
    S_ICLR,
    S_IDLE,
    S_DISPATCH,
    S_TAKE,
    S_UNLINK,
    S_MESET,
    S_PFILL,
    S_PLINK,
    S_PCUT,
    S_FRD0,
    S_FLINK,
    S_FHEAD,
    S_SQ,
    S_SCMP,
    S_DCUT,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t  op;
    logic    st_we;
    status_t status;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic hdr_zero;
    logic hsucc_zero;
    logic pos_bad;
    logic rd_zero;
    logic match;
    logic steps_last;
    logic clr_last;
    logic out_free;
  } dp_flags_t;

endpackage
`default_nettype wire

>>> hdl/cllt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module cllt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output logic      [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd <= mem[ra];
  end

endmodule
`default_nettype wire

>>> hdl/cllt_ctrl.sv
// Controller of the cursor linked list table: sequences datapath
// micro-operations per request. Depends on cllt_pkg.
`default_nettype none
module cllt_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire cllt_pkg::dp_flags_t  flags,
  output cllt_pkg::ctrl_cmd_t       cmd
);

  cllt_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= cllt_pkg::S_RCLR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op     = cllt_pkg::OP_NONE;
    cmd.st_we  = 1'b0;
    cmd.status = cllt_pkg::ST_OK;
    s_tready   = 1'b0;
    unique case (state)
      cllt_pkg::S_RCLR, cllt_pkg::S_ICLR: begin
        cmd.op = cllt_pkg::OP_CLR_STEP;
        if (flags.clr_last)
          state_next = (state == cllt_pkg::S_RCLR) ? cllt_pkg::S_IDLE : cllt_pkg::S_FINISH;
      end
      cllt_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op     = cllt_pkg::OP_LOAD;
          state_next = cllt_pkg::S_DISPATCH;
        end
      end
      cllt_pkg::S_DISPATCH: begin
        state_next = cllt_pkg::S_FINISH;
        unique case (flags.cmd) inside
          cllt_pkg::CMD_INIT: begin
            cmd.op     = cllt_pkg::OP_CLR_START;
            state_next = cllt_pkg::S_ICLR;
          end
          cllt_pkg::CMD_MAKE_EMPTY: begin
            cmd.op     = cllt_pkg::OP_RD_FREE;
            state_next = cllt_pkg::S_TAKE;
          end
          cllt_pkg::CMD_PUSH: begin
            if (flags.hdr_zero) begin
              cmd.st_we  = 1'b1;
              cmd.status = cllt_pkg::ST_EMPTY;
            end else if (flags.pos_bad) begin
              cmd.st_we  = 1'b1;
              cmd.status = cllt_pkg::ST_NOT_FOUND;
            end else begin
              cmd.op     = cllt_pkg::OP_RD_FREE;
              state_next = cllt_pkg::S_TAKE;
            end
          end
          cllt_pkg::CMD_POP: begin
            if (flags.hdr_zero || flags.hsucc_zero) begin
              cmd.st_we  = 1'b1;
              cmd.status = cllt_pkg::ST_EMPTY;
            end else begin
              cmd.op     = cllt_pkg::OP_PO_START;
              state_next = cllt_pkg::S_PCUT;
            end
          end
          cllt_pkg::CMD_FIND, cllt_pkg::CMD_FIND_PREV, cllt_pkg::CMD_DELETE: begin
            if (flags.hdr_zero || flags.hsucc_zero) begin
              cmd.st_we  = 1'b1;
              cmd.status = cllt_pkg::ST_EMPTY;
            end else begin
              cmd.op     = cllt_pkg::OP_SK_START;
              state_next = cllt_pkg::S_SQ;
            end
          end
          default: state_next = cllt_pkg::S_FINISH;
        endcase
      end
      cllt_pkg::S_TAKE: begin
        if (flags.rd_zero) begin
          cmd.st_we  = 1'b1;
          cmd.status = cllt_pkg::ST_FULL;
          state_next = cllt_pkg::S_FINISH;
        end else begin
          cmd.op     = cllt_pkg::OP_TAKE;
          state_next = cllt_pkg::S_UNLINK;
        end
      end
      cllt_pkg::S_UNLINK: begin
        cmd.op     = cllt_pkg::OP_UNLINK;
        state_next = (flags.cmd == cllt_pkg::CMD_MAKE_EMPTY) ? cllt_pkg::S_MESET
                                                             : cllt_pkg::S_PFILL;
      end
      cllt_pkg::S_MESET: begin
        cmd.op     = cllt_pkg::OP_ME_SET;
        state_next = cllt_pkg::S_FINISH;
      end
      cllt_pkg::S_PFILL: begin
        cmd.op     = cllt_pkg::OP_PU_FILL;
        state_next = cllt_pkg::S_PLINK;
      end
      cllt_pkg::S_PLINK: begin
        cmd.op     = cllt_pkg::OP_PU_LINK;
        state_next = cllt_pkg::S_FINISH;
      end
      cllt_pkg::S_PCUT: begin
        cmd.op     = cllt_pkg::OP_PO_CUT;
        state_next = cllt_pkg::S_FRD0;
      end
      cllt_pkg::S_FRD0: begin
        cmd.op     = cllt_pkg::OP_FR_RD0;
        state_next = cllt_pkg::S_FLINK;
      end
      cllt_pkg::S_FLINK: begin
        cmd.op     = cllt_pkg::OP_FR_LINK;
        state_next = cllt_pkg::S_FHEAD;
      end
      cllt_pkg::S_FHEAD: begin
        cmd.op     = cllt_pkg::OP_FR_HEAD;
        state_next = cllt_pkg::S_FINISH;
      end
      cllt_pkg::S_SQ: begin
        if (flags.rd_zero) begin
          cmd.st_we  = 1'b1;
          cmd.status = cllt_pkg::ST_NOT_FOUND;
          state_next = cllt_pkg::S_FINISH;
        end else begin
          cmd.op     = cllt_pkg::OP_SK_Q;
          state_next = cllt_pkg::S_SCMP;
        end
      end
      cllt_pkg::S_SCMP: begin
        if (flags.match) begin
          cmd.op     = cllt_pkg::OP_SK_HIT;
          state_next = (flags.cmd == cllt_pkg::CMD_DELETE) ? cllt_pkg::S_DCUT
                                                           : cllt_pkg::S_FINISH;
        end else if (flags.steps_last || flags.rd_zero) begin
          cmd.st_we  = 1'b1;
          cmd.status = cllt_pkg::ST_NOT_FOUND;
          state_next = cllt_pkg::S_FINISH;
        end else begin
          cmd.op = cllt_pkg::OP_SK_STEP;
        end
      end
      cllt_pkg::S_DCUT: begin
        cmd.op     = cllt_pkg::OP_DL_CUT;
        state_next = cllt_pkg::S_FRD0;
      end
      cllt_pkg::S_FINISH: begin
        if (flags.out_free) begin
          cmd.op     = cllt_pkg::OP_FINISH;
          state_next = cllt_pkg::S_IDLE;
        end
      end
      default: state_next = cllt_pkg::S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (state == cllt_pkg::S_IDLE && s_tvalid) |=> state == cllt_pkg::S_DISPATCH)
    else $error("accepted request not dispatched");
`endif

endmodule
`default_nettype wire

>>> hdl/cllt_dpath.sv
// Datapath of the cursor linked list table: link and element RAMs, list
// registers, search cursor and the output register. Depends on cllt_pkg, cllt_ram.
`default_nettype none
module cllt_dpath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [39:0]         s_tdata,
  input  wire logic                m_tready,
  output logic                     m_tvalid,
  output logic [47:0]              m_tdata,
  input  wire cllt_pkg::ctrl_cmd_t cmd,
  output cllt_pkg::dp_flags_t      flags
);

  localparam int IW = cllt_pkg::IW;
  localparam int VB = cllt_pkg::VALUE_BITS;
  localparam logic [IW-1:0] LAST = IW'(cllt_pkg::ENTRIES - 1);

  cllt_pkg::cmd_t      cmd_r;
  cllt_pkg::status_t   st;
  logic [VB-1:0]       key, rval;
  logic [3:0]          pos;
  logic [IW-1:0]       pos_idx;
  logic [IW-1:0]       hdr, rear, cnt, hsucc, p, q, f, after, steps, idx, rpos;
  logic                out_valid, out_free;
  logic [47:0]         out_data;

  logic          nl_we, pl_we, el_we;
  logic [IW-1:0] nl_wa, nl_wd, nl_ra, nl_rd;
  logic [IW-1:0] pl_wa, pl_wd, pl_ra, pl_rd;
  logic [IW-1:0] el_wa, el_ra;
  logic [VB-1:0] el_wd, el_rd;

  assign pos_idx  = IW'(pos);
  assign out_free = !out_valid || m_tready;

  always_comb begin
    nl_we = 1'b0; nl_wa = '0; nl_wd = '0; nl_ra = '0;
    pl_we = 1'b0; pl_wa = '0; pl_wd = '0; pl_ra = '0;
    el_we = 1'b0; el_wa = '0; el_wd = '0; el_ra = '0;
    unique case (cmd.op)
      cllt_pkg::OP_CLR_STEP: begin
        nl_we = 1'b1; nl_wa = idx; nl_wd = (idx == LAST) ? '0 : idx + IW'(1);
        pl_we = 1'b1; pl_wa = idx; pl_wd = (idx == '0) ? '0 : idx - IW'(1);
      end
      cllt_pkg::OP_RD_FREE: nl_ra = '0;
      cllt_pkg::OP_TAKE:    nl_ra = nl_rd;
      cllt_pkg::OP_UNLINK: begin
        nl_we = 1'b1; nl_wa = '0; nl_wd = nl_rd; nl_ra = pos_idx;
      end
      cllt_pkg::OP_ME_SET: begin
        nl_we = 1'b1; nl_wa = p; nl_wd = '0;
        pl_we = 1'b1; pl_wa = p; pl_wd = '0;
      end
      cllt_pkg::OP_PU_FILL: begin
        el_we = 1'b1; el_wa = p; el_wd = key;
        nl_we = 1'b1; nl_wa = p; nl_wd = nl_rd;
        pl_we = 1'b1; pl_wa = p; pl_wd = pos_idx;
      end
      cllt_pkg::OP_PU_LINK: begin
        nl_we = 1'b1; nl_wa = pos_idx; nl_wd = p;
        pl_we = (after != '0); pl_wa = after; pl_wd = p;
      end
      cllt_pkg::OP_PO_START: begin
        pl_ra = rear; el_ra = rear;
      end
      cllt_pkg::OP_PO_CUT: begin
        nl_we = 1'b1; nl_wa = pl_rd; nl_wd = '0;
      end
      cllt_pkg::OP_FR_RD0: nl_ra = '0;
      cllt_pkg::OP_FR_LINK: begin
        nl_we = 1'b1; nl_wa = f; nl_wd = nl_rd;
        pl_we = 1'b1; pl_wa = f; pl_wd = '0;
      end
      cllt_pkg::OP_FR_HEAD: begin
        nl_we = 1'b1; nl_wa = '0; nl_wd = f;
      end
      cllt_pkg::OP_SK_START: nl_ra = hdr;
      cllt_pkg::OP_SK_Q, cllt_pkg::OP_SK_STEP: begin
        nl_ra = nl_rd; el_ra = nl_rd;
      end
      cllt_pkg::OP_DL_CUT: begin
        nl_we = 1'b1; nl_wa = p; nl_wd = after;
        pl_we = (after != '0); pl_wa = after; pl_wd = p;
      end
      default: ;
    endcase
  end

  cllt_ram #(.WIDTH(IW), .DEPTH(cllt_pkg::ENTRIES)) u_next (
    .clk(clk), .we(nl_we), .wa(nl_wa), .wd(nl_wd), .ra(nl_ra), .rd(nl_rd)
  );
  cllt_ram #(.WIDTH(IW), .DEPTH(cllt_pkg::ENTRIES)) u_prev (
    .clk(clk), .we(pl_we), .wa(pl_wa), .wd(pl_wd), .ra(pl_ra), .rd(pl_rd)
  );
  cllt_ram #(.WIDTH(VB), .DEPTH(cllt_pkg::ENTRIES)) u_elem (
    .clk(clk), .we(el_we), .wa(el_wa), .wd(el_wd), .ra(el_ra), .rd(el_rd)
  );

  // list state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr       <= '0;
      rear      <= '0;
      cnt       <= '0;
      hsucc     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      // mirror of the header's next link, tracked on every link write to the header entry
      if (nl_we && nl_wa == hdr) hsucc <= nl_wd;
      if (cmd.st_we) st <= cmd.status;
      if (m_tready && cmd.op != cllt_pkg::OP_FINISH) out_valid <= 1'b0;
      unique case (cmd.op)
        cllt_pkg::OP_LOAD: begin
          cmd_r <= cllt_pkg::cmd_t'(s_tdata[2:0]);
          key   <= VB'(s_tdata[34:3]);
          pos   <= s_tdata[38:35];
          st    <= cllt_pkg::ST_OK;
          rpos  <= '0;
          rval  <= '0;
        end
        cllt_pkg::OP_CLR_START: begin
          hdr <= '0; rear <= '0; cnt <= '0; idx <= '0;
        end
        cllt_pkg::OP_CLR_STEP: idx <= idx + IW'(1);
        cllt_pkg::OP_TAKE:     p <= nl_rd;
        cllt_pkg::OP_ME_SET: begin
          hdr <= p; rear <= p; cnt <= '0; rpos <= p; hsucc <= '0;
        end
        cllt_pkg::OP_PU_FILL: after <= nl_rd;
        cllt_pkg::OP_PU_LINK: begin
          if (after == '0) rear <= p;
          cnt  <= cnt + IW'(1);
          rpos <= p;
        end
        cllt_pkg::OP_PO_START: f <= rear;
        cllt_pkg::OP_PO_CUT: begin
          rear <= pl_rd;
          rval <= el_rd;
        end
        cllt_pkg::OP_FR_HEAD:  if (cnt != '0) cnt <= cnt - IW'(1);
        cllt_pkg::OP_SK_START: begin
          p <= hdr; steps <= '0;
        end
        cllt_pkg::OP_SK_Q:     q <= nl_rd;
        cllt_pkg::OP_SK_STEP: begin
          p <= q; q <= nl_rd; steps <= steps + IW'(1);
        end
        cllt_pkg::OP_SK_HIT: begin
          after <= nl_rd;
          f     <= q;
          rpos  <= (cmd_r == cllt_pkg::CMD_FIND_PREV) ? p : q;
        end
        cllt_pkg::OP_DL_CUT:   if (after == '0) rear <= p;
        cllt_pkg::OP_FINISH: begin
          out_valid <= 1'b1;
          out_data  <= {5'd0, (hdr == '0 || hsucc == '0), 4'(cnt), 32'(rval),
                        4'(rpos), st};
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign flags.cmd        = cmd_r;
  assign flags.hdr_zero   = (hdr == '0);
  assign flags.hsucc_zero = (hsucc == '0);
  assign flags.pos_bad    = (pos == 4'd0) || (32'(pos) >= cllt_pkg::ENTRIES);
  assign flags.rd_zero    = (nl_rd == '0);
  assign flags.match      = (el_rd == key);
  assign flags.steps_last = (steps == LAST);
  assign flags.clr_last   = (idx == LAST);
  assign flags.out_free   = out_free;

`ifndef NO_ASSERTIONS
  a_header_fresh: assert property (@(posedge clk) disable iff (rst)
    cmd.op == cllt_pkg::OP_ME_SET |=> (hdr != '0 && hsucc == '0))
    else $error("new header not empty");
  a_finish_room: assert property (@(posedge clk) disable iff (rst)
    cmd.op == cllt_pkg::OP_FINISH |-> out_free)
    else $error("result overwrites a pending one");
  a_free_head_write: assert property (@(posedge clk) disable iff (rst)
    (nl_we && nl_wa == '0) |-> (cmd.op == cllt_pkg::OP_UNLINK ||
      cmd.op == cllt_pkg::OP_FR_HEAD || cmd.op == cllt_pkg::OP_PO_CUT ||
      cmd.op == cllt_pkg::OP_CLR_STEP))
    else $error("free list head written by wrong step");
`endif

endmodule
`default_nettype wire

>>> hdl/cursor_linked_list_table.sv
// Cursor linked list table: one request at a time, the next taken once the result is registered.
// find/find_previous and delete search by walking one link per cycle through
// the next-link RAM.
// After reset a pass rebuilds the link RAMs; no request is taken during it.
// Depends on cllt_pkg, cllt_ctrl, cllt_dpath, cllt_ram.
`default_nettype none
module cursor_linked_list_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // command[2:0], value[34:3], position[38:35]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata   // status[1:0], result_position[5:2],
                                     // result_value[37:6], count[41:38],
                                     // list_empty[42]
);

  cllt_pkg::ctrl_cmd_t cmd;
  cllt_pkg::dp_flags_t flags;

  cllt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .flags(flags), .cmd(cmd)
  );

  cllt_dpath u_dpath (
    .clk(clk), .rst(rst), .s_tdata(s_tdata), .m_tready(m_tready),
    .m_tvalid(m_tvalid), .m_tdata(m_tdata), .cmd(cmd), .flags(flags)
  );

endmodule
`default_nettype wire
